// ----- hw/rtl/y2r_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pkg: shared types for the YUY2 to RGB orientation core
// Beat layouts, configuration register indexes, lane control and mapping
// configuration used by the lanes and the top level.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ExtentW = 13;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIRROR_X      = 3'd0,
    CFG_MIRROR_Y      = 3'd1,
    CFG_QUARTER_TURNS = 3'd2,
    CFG_COLS_USED     = 3'd3,
    CFG_ROWS_USED     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    coord_t     src_row;
    coord_t     src_col;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    coord_t     dst_row_first;
    coord_t     dst_col_first;
    coord_t     dst_row_second;
    coord_t     dst_col_second;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } place_t;

  // Low 12 bits of the saturated extents suffice: results wrap modulo 4096.
  typedef struct packed {
    logic       mirror_x;
    logic       mirror_y;
    logic [1:0] quarter_turns;
    coord_t     width;
    coord_t     height;
  } orient_cfg_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
  } pipe_ctrl_t;

endpackage : y2r_pkg
`default_nettype wire

// ----- hw/rtl/y2r_color_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_color_lane: one BT.601 integer color lane
// Stage one forms the luma and chroma products, stage two sums, rounds,
// shifts and clamps to one RGB pixel.
// ----------------------------------------------------------------------------
module y2r_color_lane
  import y2r_pkg::*;
(
  input  wire logic       clk_i,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire logic [7:0] luma_i,
  input  wire logic [7:0] cb_i,
  input  wire logic [7:0] cr_i,
  output rgb_t            rgb_o
);

  logic signed [9:0]  y_off, u_off, v_off;
  logic signed [19:0] t_d, t_q;
  logic signed [19:0] rv_d, rv_q;
  logic signed [19:0] gc_d, gc_q;
  logic signed [19:0] bu_d, bu_q;
  logic signed [19:0] r_sum, g_sum, b_sum;
  rgb_t               rgb_d, rgb_q;

  function automatic logic [7:0] clamp8(input logic signed [19:0] sum);
    logic [7:0] res;
    if (sum[19]) begin
      res = 8'd0;
    end else if (|sum[18:16]) begin
      res = 8'hFF;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

  always_comb begin
    y_off = $signed({2'b00, luma_i}) - 10'sd16;
    u_off = $signed({2'b00, cb_i}) - 10'sd128;
    v_off = $signed({2'b00, cr_i}) - 10'sd128;
    t_d   = 20'(y_off) * 20'sd298;
    rv_d  = 20'(v_off) * 20'sd409;
    gc_d  = 20'(u_off) * 20'sd100 + 20'(v_off) * 20'sd208;
    bu_d  = 20'(u_off) * 20'sd516;
  end

  always_comb begin
    r_sum = t_q + rv_q + 20'sd128;
    g_sum = t_q - gc_q + 20'sd128;
    b_sum = t_q + bu_q + 20'sd128;
    rgb_d.red   = clamp8(r_sum);
    rgb_d.green = clamp8(g_sum);
    rgb_d.blue  = clamp8(b_sum);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      t_q  <= t_d;
      rv_q <= rv_d;
      gc_q <= gc_d;
      bu_q <= bu_d;
    end
    if (ctrl_i.adv2) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule : y2r_color_lane
`default_nettype wire

// ----- hw/rtl/y2r_coord_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_coord_lane: destination coordinate lane for one pixel
// Applies mirror and quarter-turn mapping to one source position, with
// reversal over the clipped extent, wrapped to 12 bits.
// ----------------------------------------------------------------------------
module y2r_coord_lane
  import y2r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire pipe_ctrl_t  ctrl_i,
  input  wire orient_cfg_t cfg_i,
  input  wire coord_t      row_i,
  input  wire coord_t      col_i,
  output place_t           place_o
);

  logic   transpose, rev_row, rev_col;
  coord_t row_src, col_src, row_ext, col_ext;
  place_t place_d, s1_q, s2_q;

  always_comb begin
    transpose = cfg_i.quarter_turns[0];
    if (transpose) begin
      rev_row = (cfg_i.quarter_turns == 2'd3) ^ cfg_i.mirror_y;
      rev_col = (cfg_i.quarter_turns == 2'd1) ^ cfg_i.mirror_x;
      row_src = col_i;
      row_ext = cfg_i.width;
      col_src = row_i;
      col_ext = cfg_i.height;
    end else begin
      rev_row = (cfg_i.quarter_turns == 2'd2) ^ cfg_i.mirror_y;
      rev_col = (cfg_i.quarter_turns == 2'd2) ^ cfg_i.mirror_x;
      row_src = row_i;
      row_ext = cfg_i.height;
      col_src = col_i;
      col_ext = cfg_i.width;
    end
    // extent - 1 - c, modulo 4096
    place_d.row = rev_row ? (row_ext - 12'd1 - row_src) : row_src;
    place_d.col = rev_col ? (col_ext - 12'd1 - col_src) : col_src;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      s1_q <= place_d;
    end
    if (ctrl_i.adv2) begin
      s2_q <= s1_q;
    end
  end

  assign place_o = s2_q;

endmodule : y2r_coord_lane
`default_nettype wire

// ----- hw/rtl/yuy2_to_rgb_orient_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yuy2_to_rgb_orient_core: YUY2 macropixel to RGB with mirror and rotation
//
//   port group  direction  beat
//   in_*        input      one YUY2 macropixel with source row and column
//   out_*       output     two RGB pixels with destination rows and columns
//   cfg_*       input      register write: index, 13-bit data
//
// One macropixel per cycle while in_stall_o is low; an accepted beat passes stage one and stage two before out_valid_o.
// Stage one forms the color products and the mapped coordinates in two
// color lanes and two coordinate lanes; stage two clamps and merges them
// into the output register.
// Reset clears both stage valid flags and loads the register reset values.
// A stalled output holds; stage one still fills, and input stalls only when
// both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module yuy2_to_rgb_orient_core
  import y2r_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_beat_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_beat_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ExtentW-1:0]  cfg_data_i
);

  localparam coord_t MaxExtLow = coord_t'(MAX_EXTENT);

  logic               mirror_x_q, mirror_y_q;
  logic [1:0]         turns_q;
  logic [ExtentW-1:0] cols_q, rows_q;
  logic               v1_q, v2_q;
  pipe_ctrl_t         ctrl;
  orient_cfg_t        ocfg;
  coord_t             col_second;
  rgb_t               rgb_first, rgb_second;
  place_t             pl_first, pl_second;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      turns_q    <= 2'd0;
      cols_q     <= 13'd640;
      rows_q     <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIRROR_X:      mirror_x_q <= cfg_data_i[0];
        CFG_MIRROR_Y:      mirror_y_q <= cfg_data_i[0];
        CFG_QUARTER_TURNS: turns_q    <= cfg_data_i[1:0];
        CFG_COLS_USED:     cols_q     <= cfg_data_i;
        CFG_ROWS_USED:     rows_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ocfg.mirror_x      = mirror_x_q;
    ocfg.mirror_y      = mirror_y_q;
    ocfg.quarter_turns = turns_q;
    ocfg.width  = (32'(cols_q) > MAX_EXTENT) ? MaxExtLow : cols_q[CoordW-1:0];
    ocfg.height = (32'(rows_q) > MAX_EXTENT) ? MaxExtLow : rows_q[CoordW-1:0];
  end

  // Pipeline control: advance a stage when it has room downstream
  always_comb begin
    ctrl.adv2  = v1_q & (~v2_q | ~out_stall_i);
    in_stall_o = v1_q & v2_q & out_stall_i;
    ctrl.adv1  = in_valid_i & ~in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ctrl.adv1) begin
        v1_q <= 1'b1;
      end else if (ctrl.adv2) begin
        v1_q <= 1'b0;
      end
      if (ctrl.adv2) begin
        v2_q <= 1'b1;
      end else if (!out_stall_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  assign col_second = in_data_i.src_col + 12'd1;

  y2r_color_lane u_color_first (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .luma_i (in_data_i.luma_first),
    .cb_i   (in_data_i.chroma_blue),
    .cr_i   (in_data_i.chroma_red),
    .rgb_o  (rgb_first)
  );

  y2r_color_lane u_color_second (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .luma_i (in_data_i.luma_second),
    .cb_i   (in_data_i.chroma_blue),
    .cr_i   (in_data_i.chroma_red),
    .rgb_o  (rgb_second)
  );

  y2r_coord_lane u_coord_first (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cfg_i   (ocfg),
    .row_i   (in_data_i.src_row),
    .col_i   (in_data_i.src_col),
    .place_o (pl_first)
  );

  y2r_coord_lane u_coord_second (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cfg_i   (ocfg),
    .row_i   (in_data_i.src_row),
    .col_i   (col_second),
    .place_o (pl_second)
  );

  // Merge the lanes into the output beat
  always_comb begin
    out_data_o.red_first      = rgb_first.red;
    out_data_o.green_first    = rgb_first.green;
    out_data_o.blue_first     = rgb_first.blue;
    out_data_o.red_second     = rgb_second.red;
    out_data_o.green_second   = rgb_second.green;
    out_data_o.blue_second    = rgb_second.blue;
    out_data_o.dst_row_first  = pl_first.row;
    out_data_o.dst_col_first  = pl_first.col;
    out_data_o.dst_row_second = pl_second.row;
    out_data_o.dst_col_second = pl_second.col;
  end

  assign out_valid_o = v2_q;

`ifndef SYNTH
  a_stall_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && out_valid_o && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted beat not held in stage one");

  a_s1_moves_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !(out_valid_o && out_stall_i)) |=> out_valid_o)
    else $error("stage one beat lost on its way to the output");

  a_held_beat_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed or dropped");
`endif

endmodule : yuy2_to_rgb_orient_core
`default_nettype wire
